@@ rtl/omd_pkg.sv @@
// Shared types and constants of the OSC message byte decoder.
`timescale 1ns / 1ps

package omd_pkg;

  // Default depth of the type-tag store.
  localparam int OMD_MAX_TAGS = 16;

  // Argument type tags.
  localparam logic [7:0] TAG_S = 8'h73;
  localparam logic [7:0] TAG_B = 8'h62;
  localparam logic [7:0] TAG_I = 8'h69;
  localparam logic [7:0] TAG_F = 8'h66;
  localparam logic [7:0] TAG_D = 8'h64;

  // Error codes carried with each result item.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TAG   = 2'd1;
  localparam logic [1:0] ERR_OVF   = 2'd2;
  localparam logic [1:0] ERR_EARLY = 2'd3;

  // Decoder phases. PH_ARG waits for the first byte of an argument whose tag
  // has not been classified yet.
  typedef enum logic [2:0] {
    PH_ADDR,
    PH_TAGS,
    PH_ARG,
    PH_WORD,
    PH_STR,
    PH_BLEN,
    PH_BDATA,
    PH_DONE
  } phase_t;

  // Group of up to eight result bytes produced by one input item.
  typedef struct packed {
    logic [63:0] data;  // byte k in bits 8k+7:8k, sent lowest first
    logic [3:0]  cnt;   // number of result items, 0 to 8
    logic [1:0]  err;   // error code for every item of the group
    logic        fin;   // group closes the message
  } grp_t;

endpackage

@@ rtl/omd_decode.sv @@
// Input register, message state, type-tag store and per-byte decode logic.
`timescale 1ns / 1ps

module omd_decode
  import omd_pkg::*;
#(
  parameter int MAX_TAGS = OMD_MAX_TAGS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       ser_free,
  output logic       grp_load,
  output grp_t       grp
);

  localparam int TW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int CW = $clog2(MAX_TAGS + 1);

  // Input register.
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  // Message state.
  phase_t      phase_r, phase_nxt;
  logic [CW-1:0] tag_count_r, tag_count_nxt;
  logic [CW-1:0] tag_pos_r, tag_pos_nxt;
  logic [63:0] word_r, word_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] blob_r, blob_nxt;
  logic        nul_r, nul_nxt;
  logic        first_r, first_nxt;
  logic [1:0]  held_r, held_nxt;

  // Tag store with registered read port.
  logic [7:0]    tag_mem [MAX_TAGS];
  logic [7:0]    rd_q;
  logic [TW-1:0] rd_addr;
  logic          tag_wr;

  logic          adv;
  phase_t        eph;
  logic          need8;
  logic [63:0]   word_sh, blen_sh;
  logic [2:0]    cnt_inc;
  logic          word_fin, blen_fin, nul_new, str_fin, bdata_fin, tag_ovf;
  logic [31:0]   blob_dec;
  logic          adv_arg, start_arg, done_step;
  logic [1:0]    err_step;
  logic [CW-1:0] tag_pos_inc;

  assign adv       = in_v_r && ((grp.cnt == 4'd0) || ser_free);
  assign in_tready = !in_v_r || adv;
  assign grp_load  = adv && (grp.cnt != 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  // The first byte of an argument takes the phase of its tag.
  always_comb begin
    eph = phase_r;
    if (phase_r == PH_ARG) begin
      unique case (rd_q)
        TAG_I, TAG_F, TAG_D: eph = PH_WORD;
        TAG_S:               eph = PH_STR;
        TAG_B:               eph = PH_BLEN;
        default:             eph = PH_ARG;
      endcase
    end
  end

  assign need8       = (rd_q == TAG_D);
  assign word_sh     = {word_r[55:0], in_byte_r};
  assign blen_sh     = {32'd0, word_r[23:0], in_byte_r};
  assign cnt_inc     = cnt_r + 3'd1;
  assign word_fin    = (cnt_r == (need8 ? 3'd7 : 3'd3));
  assign blen_fin    = (cnt_r == 3'd3);
  assign nul_new     = nul_r || (in_byte_r == 8'd0);
  assign str_fin     = nul_new && (cnt_inc[1:0] == 2'd0);
  assign blob_dec    = (blob_r != 32'd0) ? (blob_r - 32'd1) : 32'd0;
  assign bdata_fin   = (blob_dec == 32'd0) && (cnt_inc[1:0] == 2'd0);
  assign tag_ovf     = !nul_r && (in_byte_r != 8'd0) && !first_r &&
                       (tag_count_r == CW'(MAX_TAGS));
  assign tag_pos_inc = tag_pos_r + CW'(1);
  assign tag_wr      = adv && (eph == PH_TAGS) && !nul_r && (in_byte_r != 8'd0) &&
                       !first_r && (tag_count_r < CW'(MAX_TAGS));

  // Next state.
  always_comb begin
    phase_nxt     = phase_r;
    tag_count_nxt = tag_count_r;
    tag_pos_nxt   = tag_pos_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    blob_nxt      = blob_r;
    nul_nxt       = nul_r;
    first_nxt     = first_r;
    held_nxt      = held_r;
    adv_arg       = 1'b0;
    start_arg     = 1'b0;
    unique case (eph)
      PH_ADDR: begin
        cnt_nxt = cnt_inc;
        nul_nxt = nul_new;
        if (str_fin) begin
          phase_nxt     = PH_TAGS;
          cnt_nxt       = 3'd0;
          nul_nxt       = 1'b0;
          tag_count_nxt = '0;
          first_nxt     = 1'b1;
        end
      end
      PH_TAGS: begin
        first_nxt = 1'b0;
        cnt_nxt   = cnt_inc;
        if (tag_ovf) begin
          phase_nxt = PH_DONE;
          held_nxt  = ERR_OVF;
        end else begin
          if (!nul_r) begin
            if (in_byte_r == 8'd0) begin
              nul_nxt = 1'b1;
            end else if (!first_r) begin
              tag_count_nxt = tag_count_r + CW'(1);
            end
          end
          if (nul_nxt && (cnt_inc[1:0] == 2'd0)) begin
            tag_pos_nxt = '0;
            if (tag_count_nxt == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              start_arg = 1'b1;
            end
          end
        end
      end
      PH_ARG: begin
        phase_nxt = PH_DONE;
        held_nxt  = ERR_TAG;
      end
      PH_WORD: begin
        word_nxt = word_sh;
        cnt_nxt  = cnt_inc;
        adv_arg  = word_fin;
      end
      PH_STR: begin
        cnt_nxt = cnt_inc;
        nul_nxt = nul_new;
        adv_arg = str_fin;
      end
      PH_BLEN: begin
        word_nxt = blen_sh;
        cnt_nxt  = cnt_inc;
        if (blen_fin) begin
          blob_nxt  = blen_sh[31:0];
          cnt_nxt   = 3'd0;
          phase_nxt = PH_BDATA;
          adv_arg   = (blen_sh[31:0] == 32'd0);
        end
      end
      PH_BDATA: begin
        blob_nxt = blob_dec;
        cnt_nxt  = cnt_inc;
        adv_arg  = bdata_fin;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (adv_arg) begin
      tag_pos_nxt = tag_pos_inc;
      if (tag_pos_inc >= tag_count_r) begin
        phase_nxt = PH_DONE;
      end else begin
        start_arg = 1'b1;
      end
    end
    if (start_arg) begin
      phase_nxt = PH_ARG;
      cnt_nxt   = 3'd0;
      word_nxt  = 64'd0;
      nul_nxt   = 1'b0;
    end
    done_step = (phase_nxt == PH_DONE);
    err_step  = held_nxt;
    // The final byte of a message returns everything to the address phase.
    if (in_end_r) begin
      phase_nxt     = PH_ADDR;
      tag_count_nxt = '0;
      tag_pos_nxt   = '0;
      word_nxt      = 64'd0;
      cnt_nxt       = 3'd0;
      blob_nxt      = 32'd0;
      nul_nxt       = 1'b0;
      first_nxt     = 1'b0;
      held_nxt      = ERR_NONE;
    end
  end

  // Result group of the byte in the input register.
  always_comb begin
    grp = '0;
    unique case (eph)
      PH_ADDR, PH_STR, PH_BDATA: begin
        grp.data = {56'd0, in_byte_r};
        grp.cnt  = 4'd1;
      end
      PH_TAGS: begin
        if (tag_ovf) begin
          grp.cnt = 4'd1;
          grp.err = ERR_OVF;
        end
      end
      PH_ARG: begin
        grp.cnt = 4'd1;
        grp.err = ERR_TAG;
      end
      PH_WORD: begin
        if (word_fin) begin
          grp.data = word_sh;
          grp.cnt  = need8 ? 4'd8 : 4'd4;
        end
      end
      PH_BLEN: begin
        if (blen_fin) begin
          grp.data = blen_sh;
          grp.cnt  = 4'd4;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (in_end_r) begin
      grp.fin = 1'b1;
      if (done_step) begin
        if (err_step != ERR_NONE) begin
          grp.data = 64'd0;
          grp.cnt  = 4'd1;
          grp.err  = err_step;
        end else if (grp.cnt == 4'd0) begin
          grp.data = 64'd0;
          grp.cnt  = 4'd1;
        end
      end else begin
        grp.data = 64'd0;
        grp.cnt  = 4'd1;
        grp.err  = ERR_EARLY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ADDR;
      tag_count_r <= '0;
      tag_pos_r   <= '0;
      word_r      <= 64'd0;
      cnt_r       <= 3'd0;
      blob_r      <= 32'd0;
      nul_r       <= 1'b0;
      first_r     <= 1'b0;
      held_r      <= ERR_NONE;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      tag_count_r <= tag_count_nxt;
      tag_pos_r   <= tag_pos_nxt;
      word_r      <= word_nxt;
      cnt_r       <= cnt_nxt;
      blob_r      <= blob_nxt;
      nul_r       <= nul_nxt;
      first_r     <= first_nxt;
      held_r      <= held_nxt;
    end
  end

  // The read port follows the next tag position, so the current tag is registered
  // together with the new position.
  assign rd_addr = adv ? tag_pos_nxt[TW-1:0] : tag_pos_r[TW-1:0];

  always_ff @(posedge clk) begin
    if (tag_wr) begin
      tag_mem[tag_count_r[TW-1:0]] <= in_byte_r;
    end
    rd_q <= tag_mem[rd_addr];
  end

endmodule

@@ rtl/omd_serial.sv @@
// Output register that sends a result group one byte per item.
`timescale 1ns / 1ps

module omd_serial
  import omd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  grp_t       grp,
  input  logic       grp_load,
  output logic       ser_free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [2:0] out_tuser
);

  logic [63:0] data_r;
  logic [3:0]  rem_r;
  logic [1:0]  err_r;
  logic        fin_r;
  logic        run_last;

  assign run_last   = (rem_r == 4'd1);
  assign ser_free   = (rem_r == 4'd0) || (run_last && out_tready);
  assign out_tvalid = (rem_r != 4'd0);
  assign out_tdata  = data_r[7:0];
  assign out_tlast  = run_last && fin_r;
  assign out_tuser  = {err_r, run_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 4'd0;
    end else if (grp_load) begin
      rem_r <= grp.cnt;
    end else if (out_tvalid && out_tready) begin
      rem_r <= rem_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      data_r <= grp.data;
      err_r  <= grp.err;
      fin_r  <= grp.fin;
    end else if (out_tvalid && out_tready) begin
      data_r <= {8'd0, data_r[63:8]};
    end
  end

endmodule

@@ rtl/osc_message_byte_decoder_unit.sv @@
// An accepted item is decoded from the input register into the output register.
// Throughput: one input item a cycle while each gives at most one result item and out_tready
// is high; the four or eight bytes of a numeric argument leave the single output register one
// a cycle, so a following byte with result items of its own waits until the last has left.
// Reset (rst_n low, synchronous) returns to the address phase and empties both stages.
`timescale 1ns / 1ps

module osc_message_byte_decoder_unit
  import omd_pkg::*;
#(
  parameter int MAX_TAGS = OMD_MAX_TAGS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // msg_done
  output logic [2:0] out_tuser   // [0] run_last, [2:1] error_code
);

  // The decoder registers each incoming byte, then decodes it against the
  // message state in one pass and hands a group of up to eight result bytes
  // to the output stage. Big-endian words come out byte-reversed; strings,
  // blob data and padding are copied through, and the type-tag string is
  // kept in a small store and not sent on.

  grp_t grp;
  logic grp_load;
  logic ser_free;

  omd_decode #(
    .MAX_TAGS(MAX_TAGS)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .ser_free (ser_free),
    .grp_load (grp_load),
    .grp      (grp)
  );

  // The output stage sends one byte per item and takes a new group as its
  // last byte leaves, so the next byte can be decoded meanwhile.
  omd_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp       (grp),
    .grp_load  (grp_load),
    .ser_free  (ser_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

@@ rtl/omd_checker.sv @@
// Port-level checks of the OSC message byte decoder, bound to its top level.
`timescale 1ns / 1ps

module omd_checker
  import omd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [2:0] out_tuser
);

  // The output side is empty in the cycle after a reset edge.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item shown after reset");

  // The end of a message is always the last item of its run.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("message end not on last item of run");

  // Error items stand alone and carry a zero byte.
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] != ERR_NONE) |-> out_tuser[0] && (out_tdata == 8'd0))
    else $error("error item not alone or not zero");

  // An early end always closes the message.
  a_early_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] == ERR_EARLY) |-> out_tlast)
    else $error("early end without message end");

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

endmodule

bind osc_message_byte_decoder_unit omd_checker u_omd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);
